// ----- hw/rtl/tesca_pkg.sv -----
// Shared constants, codes, types and helpers of the two-ended slab code allocator.
package tesca_pkg;

    localparam int DEF_MAX_SLABS   = 16;
    localparam int DEF_OFFSET_BITS = 24;

    localparam int W_OFF  = 25;
    localparam int W_SLAB = 4;
    localparam int W_LG   = 5;
    localparam int W_CFG  = 13;
    localparam int W_CIDX = 2;

    localparam logic OP_PROPOSE = 1'b0;
    localparam logic OP_COMMIT  = 1'b1;

    localparam logic [W_CIDX-1:0] CFG_PAGE_LG   = 2'd0;
    localparam logic [W_CIDX-1:0] CFG_GRAN_LG   = 2'd1;
    localparam logic [W_CIDX-1:0] CFG_STD_PAGES = 2'd2;

    localparam logic [W_LG-1:0]  RST_PAGE_LG   = 5'd12;
    localparam logic [W_LG-1:0]  RST_GRAN_LG   = 5'd4;
    localparam logic [W_CFG-1:0] RST_STD_PAGES = 13'd16;

    localparam logic [W_LG-1:0] LG_MIN = 5'd4;
    localparam logic [W_LG-1:0] LG_MAX = 5'd16;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_TOO_LARGE  = 2'd2,
        ST_BAD_COMMIT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CALC,
        S_SIZE,
        S_SCAN,
        S_DONE,
        S_OUT
    } t_state;

    function automatic logic [W_LG-1:0] clamp_page(input logic [W_LG-1:0] v);
        logic [W_LG-1:0] r;
        r = v;
        if (r < LG_MIN) r = LG_MIN;
        if (r > LG_MAX) r = LG_MAX;
        return r;
    endfunction

    function automatic logic [W_LG-1:0] clamp_low(input logic [W_LG-1:0] v,
                                                  input logic [W_LG-1:0] hi);
        logic [W_LG-1:0] r;
        r = v;
        if (r < LG_MIN) r = LG_MIN;
        if (r > hi) r = hi;
        return r;
    endfunction

endpackage

// ----- hw/rtl/tesca_req_if.sv -----
// Request channel: one propose or commit word.
interface tesca_req_if;
    import tesca_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [W_OFF-1:0]  code_bytes;
    logic [W_OFF-1:0]  pool_bytes;
    logic [W_LG-1:0]   pool_align_log2;
    logic [W_SLAB-1:0] target_slab;
    logic [W_OFF-1:0]  proposed_code_offset;
    logic [W_OFF-1:0]  proposed_pool_offset;

    modport source (output valid, opcode, code_bytes, pool_bytes, pool_align_log2,
                    target_slab, proposed_code_offset, proposed_pool_offset,
                    input ready);
    modport sink (input valid, opcode, code_bytes, pool_bytes, pool_align_log2,
                  target_slab, proposed_code_offset, proposed_pool_offset,
                  output ready);
endinterface

// ----- hw/rtl/tesca_rsp_if.sv -----
// Response channel: one result word per request.
interface tesca_rsp_if;
    import tesca_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [W_SLAB-1:0] slab_number;
    logic [W_OFF-1:0]  code_offset_out;
    logic [W_OFF-1:0]  pool_offset_out;
    logic [W_OFF-1:0]  rounded_code_bytes;
    logic              opened_new_slab;

    modport source (output valid, status, slab_number, code_offset_out, pool_offset_out,
                    rounded_code_bytes, opened_new_slab, input ready);
    modport sink (input valid, status, slab_number, code_offset_out, pool_offset_out,
                  rounded_code_bytes, opened_new_slab, output ready);
endinterface

// ----- hw/rtl/two_ended_slab_code_allocator_unit.sv -----
// Two-ended slab code allocator. Each request word (propose or commit) is
// taken only while the block is idle and yields exactly one response word.
// Slabs live in a row of MAX_SLABS cells; a search token walks the row one
// cell per cycle. A word passes through the prep, calc, size, scan and done
// states before the response is valid, the row walk in the scan state
// taking the longest. The next word is taken in the cycle after the
// response is accepted. Code grows up from offset 0 and the constant pool
// grows down from the slab top; the configuration registers (page size, code
// granule, standard slab pages) are written through the plain write port;
// the user must write them only while no word is in flight, which the block
// itself does not enforce.
module two_ended_slab_code_allocator_unit #(
    parameter int MAX_SLABS   = tesca_pkg::DEF_MAX_SLABS,
    parameter int OFFSET_BITS = tesca_pkg::DEF_OFFSET_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tesca_pkg::W_CIDX-1:0]  i_cfg_idx,
    input  logic [tesca_pkg::W_CFG-1:0]   i_cfg_data,
    tesca_req_if.sink                     i_req,
    tesca_rsp_if.source                   o_rsp
);
    import tesca_pkg::*;

    localparam int IW   = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int TW   = $clog2(MAX_SLABS + 1);
    localparam int VW   = OFFSET_BITS + 1;
    localparam int CW   = (OFFSET_BITS > 29) ? OFFSET_BITS + 3 : 32;
    localparam int CNTW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;

    typedef struct packed {
        logic              op;
        logic [W_SLAB-1:0] tgt;
        logic [CW-1:0]     rounded;
        logic [CW-1:0]     pool;
        logic [CW-1:0]     amask;
        logic [CW-1:0]     pmask;
        logic [TW-1:0]     total;
    } t_query;

    typedef struct packed {
        logic          found;
        logic [IW-1:0] idx;
        logic [VW-1:0] ctop;
        logic [VW-1:0] pval;
    } t_tok;

    typedef struct packed {
        logic          we;
        logic          open;
        logic [IW-1:0] idx;
        logic [VW-1:0] ctop;
        logic [VW-1:0] pbot;
        logic [VW-1:0] sbytes;
        logic          ded;
    } t_wr;

    typedef struct packed {
        logic [1:0]        status;
        logic [W_SLAB-1:0] slab;
        logic [W_OFF-1:0]  code;
        logic [W_OFF-1:0]  pool;
        logic [W_OFF-1:0]  rounded;
        logic              opened;
    } t_res;

    t_state r_state, n_state;

    logic [W_LG-1:0]  r_page_lg;
    logic [W_LG-1:0]  r_gran_lg;
    logic [W_CFG-1:0] r_std_pages;

    logic              r_op;
    logic [W_OFF-1:0]  r_code;
    logic [W_OFF-1:0]  r_pool;
    logic [W_LG-1:0]   r_alg;
    logic [W_SLAB-1:0] r_tgt;
    logic [W_OFF-1:0]  r_pco;
    logic [W_OFF-1:0]  r_ppo;

    logic [W_LG-1:0] r_plg;
    logic [CW-1:0]   r_pmask, r_gmask, r_amask;
    logic [CW-1:0]   r_rounded, r_rcpg, r_rppg, r_std;
    logic [CW-1:0]   r_size;
    logic            r_use_std;
    logic [TW-1:0]   r_total, n_total;
    logic [CNTW-1:0] r_cnt;
    t_res            r_res, n_res;

    logic [W_LG-1:0] plg, glg, alg;
    logic [CW-1:0]   minsz, std_pages;
    logic [CW-1:0]   ps_new, cpco, cppo;
    logic            bad;

    t_query query;
    t_wr    wr;
    t_tok   tok [MAX_SLABS+1];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_lg   <= RST_PAGE_LG;
            r_gran_lg   <= RST_GRAN_LG;
            r_std_pages <= RST_STD_PAGES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAGE_LG:   r_page_lg   <= i_cfg_data[W_LG-1:0];
                CFG_GRAN_LG:   r_gran_lg   <= i_cfg_data[W_LG-1:0];
                CFG_STD_PAGES: r_std_pages <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_PREP;
            S_PREP: n_state = S_CALC;
            S_CALC: n_state = S_SIZE;
            S_SIZE: n_state = S_SCAN;
            S_SCAN: if (r_cnt == CNTW'(MAX_SLABS - 1)) n_state = S_DONE;
            S_DONE: n_state = S_OUT;
            S_OUT:  if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        o_rsp.valid = (r_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (r_state == S_SIZE) r_cnt <= '0;
            else if (r_state == S_SCAN) r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // datapath
    always_comb begin
        plg       = clamp_page(r_page_lg);
        glg       = clamp_low(r_gran_lg, plg);
        alg       = (r_alg > plg) ? plg : r_alg;
        std_pages = (r_std_pages == '0) ? CW'(1) : CW'(r_std_pages);
        minsz     = r_rcpg + ((r_pool == '0) ? '0 : r_rppg);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op   <= i_req.opcode;
            r_code <= i_req.code_bytes;
            r_pool <= i_req.pool_bytes;
            r_alg  <= i_req.pool_align_log2;
            r_tgt  <= i_req.target_slab;
            r_pco  <= i_req.proposed_code_offset;
            r_ppo  <= i_req.proposed_pool_offset;
        end
        if (r_state == S_PREP) begin
            r_plg   <= plg;
            r_pmask <= (CW'(1) << plg) - CW'(1);
            r_gmask <= (CW'(1) << glg) - CW'(1);
            r_amask <= (CW'(1) << alg) - CW'(1);
        end
        if (r_state == S_CALC) begin
            r_rounded <= (CW'(r_code) + r_gmask) & ~r_gmask;
            r_rcpg    <= (CW'(r_code) + r_pmask) & ~r_pmask;
            r_rppg    <= (CW'(r_pool) + r_pmask) & ~r_pmask;
            r_std     <= std_pages << r_plg;
        end
        if (r_state == S_SIZE) begin
            r_use_std <= (minsz <= r_std);
            r_size    <= (minsz <= r_std) ? r_std : minsz;
        end
        if (r_state == S_DONE) r_res <= n_res;
    end

    assign query = '{op: r_op, tgt: r_tgt, rounded: r_rounded, pool: CW'(r_pool),
                     amask: r_amask, pmask: r_pmask, total: r_total};

    assign tok[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLABS; gi++) begin : g_cell
            tesca_cell #(
                .IDX(gi), .IW(IW), .VW(VW), .CW(CW), .TW(TW),
                .t_query(t_query), .t_tok(t_tok), .t_wr(t_wr)
            ) u_cell (
                .i_clk  (i_clk),
                .i_query(query),
                .i_wr   (wr),
                .i_tok  (tok[gi]),
                .o_tok  (tok[gi+1])
            );
        end
    endgenerate

    // decision at the end of the row walk
    always_comb begin
        n_res   = '0;
        n_total = r_total;
        wr      = '0;
        cpco    = CW'(r_pco);
        cppo    = CW'(r_ppo);
        if (CW'(r_pool) == '0 || CW'(r_pool) > r_size) ps_new = r_size;
        else ps_new = (r_size - CW'(r_pool)) & ~r_amask;
        bad = !tok[MAX_SLABS].found || (r_code == '0) ||
              (CW'(tok[MAX_SLABS].ctop) != cpco) ||
              (cppo > CW'(tok[MAX_SLABS].pval)) ||
              ((cpco + r_rounded) > (cppo & ~r_pmask));

        if (r_state == S_DONE) begin
            if (r_op == OP_PROPOSE) begin
                if (r_use_std && tok[MAX_SLABS].found) begin
                    n_res.status  = ST_OK;
                    n_res.slab    = W_SLAB'(tok[MAX_SLABS].idx);
                    n_res.code    = W_OFF'(CW'(tok[MAX_SLABS].ctop));
                    n_res.pool    = W_OFF'(CW'(tok[MAX_SLABS].pval));
                    n_res.rounded = r_rounded[W_OFF-1:0];
                end else if (r_size > (CW'(1) << OFFSET_BITS)) begin
                    n_res.status = ST_TOO_LARGE;
                end else if (r_total >= TW'(MAX_SLABS)) begin
                    n_res.status = ST_FULL;
                end else begin
                    wr.we         = 1'b1;
                    wr.open       = 1'b1;
                    wr.idx        = IW'(r_total);
                    wr.ctop       = '0;
                    wr.pbot       = r_size[VW-1:0];
                    wr.sbytes     = r_size[VW-1:0];
                    wr.ded        = !r_use_std;
                    n_total       = r_total + TW'(1);
                    n_res.status  = ST_OK;
                    n_res.slab    = W_SLAB'(r_total);
                    n_res.pool    = ps_new[W_OFF-1:0];
                    n_res.rounded = r_rounded[W_OFF-1:0];
                    n_res.opened  = 1'b1;
                end
            end else begin
                n_res.slab = r_tgt;
                if (bad) begin
                    n_res.status = ST_BAD_COMMIT;
                end else begin
                    wr.we         = 1'b1;
                    wr.idx        = tok[MAX_SLABS].idx;
                    wr.ctop       = VW'(cpco + r_rounded);
                    wr.pbot       = VW'(cppo);
                    n_res.status  = ST_OK;
                    n_res.code    = r_pco;
                    n_res.pool    = r_ppo;
                    n_res.rounded = r_rounded[W_OFF-1:0];
                end
            end
        end
    end

    always_comb begin
        o_rsp.status             = r_res.status;
        o_rsp.slab_number        = r_res.slab;
        o_rsp.code_offset_out    = r_res.code;
        o_rsp.pool_offset_out    = r_res.pool;
        o_rsp.rounded_code_bytes = r_res.rounded;
        o_rsp.opened_new_slab    = r_res.opened;
    end

endmodule

// ----- hw/rtl/tesca_cell.sv -----
// One slab cell: holds a slab's frontiers and passes the search token on.
module tesca_cell #(
    parameter int  IDX = 0,
    parameter int  IW  = 4,
    parameter int  VW  = 25,
    parameter int  CW  = 32,
    parameter int  TW  = 5,
    parameter type t_query = logic,
    parameter type t_tok   = logic,
    parameter type t_wr    = logic
) (
    input  logic   i_clk,
    input  t_query i_query,
    input  t_wr    i_wr,
    input  t_tok   i_tok,
    output t_tok   o_tok
);
    import tesca_pkg::*;

    logic [VW-1:0] r_ctop;
    logic [VW-1:0] r_pbot;
    logic [VW-1:0] r_sbytes;
    logic          r_ded;
    t_tok          r_tok;
    t_tok          n_tok;

    logic [CW-1:0] newcode;
    logic [CW-1:0] pb;
    logic [CW-1:0] ps;
    logic          live;
    logic          room;
    logic          tgt_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.we && i_wr.idx == IW'(IDX)) begin
            r_ctop <= i_wr.ctop;
            r_pbot <= i_wr.pbot;
            if (i_wr.open) begin
                r_sbytes <= i_wr.sbytes;
                r_ded    <= i_wr.ded;
            end
        end
        r_tok <= n_tok;
    end

    always_comb begin
        live    = TW'(IDX) < i_query.total;
        newcode = CW'(r_ctop) + i_query.rounded;
        pb      = CW'(r_pbot);
        if (i_query.pool == '0 || i_query.pool > pb) ps = pb;
        else ps = (pb - i_query.pool) & ~i_query.amask;
        room    = (newcode <= CW'(r_sbytes)) && (i_query.pool <= pb) &&
                  (newcode <= (ps & ~i_query.pmask));
        tgt_hit = (IDX < 16) && (W_SLAB'(IDX) == i_query.tgt);

        n_tok = i_tok;
        if (!i_tok.found) begin
            if (i_query.op == OP_PROPOSE) begin
                if (live && !r_ded && room) begin
                    n_tok.found = 1'b1;
                    n_tok.idx   = IW'(IDX);
                    n_tok.ctop  = r_ctop;
                    n_tok.pval  = ps[VW-1:0];
                end
            end else begin
                if (live && tgt_hit) begin
                    n_tok.found = 1'b1;
                    n_tok.idx   = IW'(IDX);
                    n_tok.ctop  = r_ctop;
                    n_tok.pval  = r_pbot;
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule
